// File: rtl/ucv_pkg.sv
// ucv_pkg: shared types, constants and per-byte parse function for the UDP checksum verifier.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package ucv_pkg;

   // Link header length ahead of the IPv4 header, in bytes.
   localparam logic [15:0] LINK_HEADER_BYTES = 16'd14;
   localparam logic [15:0] WORD_POS_MAX      = 16'hFFFF;
   localparam logic [3:0]  MIN_IHL           = 4'd5;
   localparam logic [7:0]  UDP_PROTOCOL      = 8'd17;
   localparam logic [15:0] UDP_HEADER_BYTES  = 16'd8;
   localparam logic [15:0] CKSUM_OFFSET      = 16'd6;

   // IPv4 header byte offsets
   localparam logic [15:0] IP_VER_IHL  = 16'd0;
   localparam logic [15:0] IP_TTL      = 16'd8;
   localparam logic [15:0] IP_PROTO    = 16'd9;
   localparam logic [15:0] IP_SRC_ADDR = 16'd12;
   localparam logic [15:0] IP_DST_END  = 16'd19;

   // UDP header byte offsets
   localparam logic [15:0] UDP_LEN_HI  = 16'd4;
   localparam logic [15:0] UDP_LEN_LO  = 16'd5;
   localparam logic [15:0] UDP_PORTS   = 16'd4;

   // Per-frame parse state.
   typedef struct packed {
      logic [15:0] word_position;
      logic [3:0]  header_words;
      logic        udp_flag;
      logic [15:0] segment_length;
      logic [15:0] bytes_left;
      logic [15:0] held_checksum;
      logic [31:0] held_ports;
      logic [7:0]  held_ttl;
   } frame_type;

   typedef struct packed {
      frame_type   st;
      logic [15:0] add;
   } byte_step_type;

   // Frame snapshot handed from the parser to the sum stage.
   typedef struct packed {
      logic [31:0] sequence_number;
      logic [31:0] running_sum;
      frame_type   frame;
   } finish_type;

   // Pre-fold sum and status handed to the result stage.
   typedef struct packed {
      logic [31:0] sequence_number;
      logic [31:0] held_ports;
      logic [7:0]  held_ttl;
      logic [15:0] held_checksum;
      logic [31:0] total;
      logic        length_error;
   } sum_type;

   // Place a byte in the upper lane at even offsets, the lower lane at odd ones.
   function automatic logic [15:0] placed(logic odd, logic [7:0] b);
      return odd ? {8'h00, b} : {b, 8'h00};
   endfunction

   // Advance the parse state by one frame byte.
   function automatic byte_step_type take_byte(frame_type s, logic [7:0] b);
      byte_step_type r;
      logic [15:0]   ip;
      logic [15:0]   off;
      logic [15:0]   u;
      logic [15:0]   seg;
      r     = '{st: s, add: 16'h0000};
      ip    = s.word_position - LINK_HEADER_BYTES;
      if (s.word_position != WORD_POS_MAX) begin
         r.st.word_position = s.word_position + 16'd1;
         if (s.word_position >= LINK_HEADER_BYTES) begin
            if (ip == IP_VER_IHL) begin
               r.st.header_words = (b[3:0] < MIN_IHL) ? MIN_IHL : b[3:0];
            end
            if (ip == IP_TTL) begin
               r.st.held_ttl = b;
            end
            if (ip == IP_PROTO) begin
               r.st.udp_flag = (b == UDP_PROTOCOL);
            end
            if (ip >= IP_SRC_ADDR && ip <= IP_DST_END) begin
               r.add = placed(ip[0], b);
            end
            off = {10'b0, r.st.header_words, 2'b00};
            u   = ip - off;
            if (r.st.header_words != 4'd0 && ip >= off) begin
               seg = r.st.segment_length;
               priority if (u < UDP_PORTS) begin
                  r.st.held_ports = {r.st.held_ports[23:0], b};
               end else if (u == UDP_LEN_HI) begin
                  r.st.segment_length = {b, seg[7:0]};
               end else if (u == UDP_LEN_LO) begin
                  r.st.segment_length = {seg[15:8], b};
                  r.st.bytes_left = ({seg[15:8], b} > CKSUM_OFFSET) ?
                                    {seg[15:8], b} - CKSUM_OFFSET : 16'h0000;
               end else if (u < UDP_HEADER_BYTES) begin
                  r.st.held_checksum = {r.st.held_checksum[7:0], b};
                  if (r.st.bytes_left != 16'h0000) begin
                     r.st.bytes_left = r.st.bytes_left - 16'd1;
                  end
               end else if (r.st.bytes_left != 16'h0000) begin
                  r.st.bytes_left = r.st.bytes_left - 16'd1;
                  r.add = placed(u[0], b);
               end
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/ucv_parser.sv
// ucv_parser: input beat register, per-frame parse state and UDP frame counter.
// Depends on ucv_pkg (frame_type, finish_type, take_byte).
`default_nettype none

module ucv_parser import ucv_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        req_tlast,
   input  wire logic        fin_ready,
   output logic             fin_valid,
   output finish_type       fin
);

   logic          in_valid_ff, in_valid_in;
   logic [15:0]   in_word_ff;
   logic          in_single_ff;
   logic          in_last_ff;
   frame_type     frame_ff, frame_in;
   logic [31:0]   run_sum_ff, run_sum_in;
   logic [31:0]   udp_count_ff, udp_count_in;
   logic          fin_valid_ff, fin_valid_in;
   finish_type    fin_ff, fin_in;

   byte_step_type step_hi, step_lo;
   frame_type     frame_next;
   logic [16:0]   beat_add;
   logic [31:0]   run_next;
   logic          fin_free;
   logic          fire;
   logic          load;

   assign fin_free   = !fin_valid_ff || fin_ready;
   assign fire       = in_valid_ff && (!in_last_ff || fin_free);
   assign req_tready = !in_valid_ff || fire;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      step_hi    = take_byte(frame_ff, in_word_ff[15:8]);
      step_lo    = take_byte(step_hi.st, in_word_ff[7:0]);
      frame_next = in_single_ff ? step_hi.st : step_lo.st;
      beat_add   = {1'b0, step_hi.add} + (in_single_ff ? 17'd0 : {1'b0, step_lo.add});
      run_next   = run_sum_ff + {15'b0, beat_add};
   end

   always_comb begin
      in_valid_in  = load ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      frame_in     = frame_ff;
      run_sum_in   = run_sum_ff;
      udp_count_in = udp_count_ff;
      fin_in       = fin_ff;
      fin_valid_in = fin_valid_ff && !fin_ready;
      if (fire) begin
         if (in_last_ff) begin
            frame_in   = '0;
            run_sum_in = 32'h0;
            if (frame_next.udp_flag) begin
               udp_count_in = udp_count_ff + 32'd1;
               fin_in       = '{sequence_number: udp_count_ff + 32'd1,
                                running_sum:     run_next,
                                frame:           frame_next};
               fin_valid_in = 1'b1;
            end
         end else begin
            frame_in   = frame_next;
            run_sum_in = run_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         frame_ff     <= '0;
         run_sum_ff   <= 32'h0;
         udp_count_ff <= 32'h0;
         fin_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         frame_ff     <= frame_in;
         run_sum_ff   <= run_sum_in;
         udp_count_ff <= udp_count_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_word_ff   <= req_tdata;
         in_single_ff <= req_tuser;
         in_last_ff   <= req_tlast;
      end
      fin_ff <= fin_in;
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

`default_nettype wire

// File: rtl/ucv_sum.sv
// ucv_sum: adds pseudo-header terms to the frame sum and flags short segments.
// Depends on ucv_pkg (finish_type, sum_type, constants).
`default_nettype none

module ucv_sum import ucv_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic fin_valid,
   output logic      fin_ready,
   input  wire finish_type fin,
   output logic      sum_valid,
   input  wire logic sum_ready,
   output sum_type   sum
);

   logic        sum_valid_ff, sum_valid_in;
   sum_type     sum_ff, sum_in;
   logic [15:0] seg;
   logic [15:0] hdr_src, hdr_dst, hdr_len;
   logic [15:0] need;
   logic        take;

   assign fin_ready = !sum_valid_ff || sum_ready;
   assign take      = fin_valid && fin_ready;

   always_comb begin
      seg = fin.frame.segment_length;
      // Only UDP header bytes that fall inside the UDP length count.
      hdr_src = {(seg > 16'd0) ? fin.frame.held_ports[31:24] : 8'h00,
                 (seg > 16'd1) ? fin.frame.held_ports[23:16] : 8'h00};
      hdr_dst = {(seg > 16'd2) ? fin.frame.held_ports[15:8]  : 8'h00,
                 (seg > 16'd3) ? fin.frame.held_ports[7:0]   : 8'h00};
      hdr_len = {(seg > 16'd4) ? seg[15:8] : 8'h00,
                 (seg > 16'd5) ? seg[7:0]  : 8'h00};
      need = LINK_HEADER_BYTES + {10'b0, fin.frame.header_words, 2'b00} + CKSUM_OFFSET;

      sum_in.sequence_number = fin.sequence_number;
      sum_in.held_ports      = fin.frame.held_ports;
      sum_in.held_ttl        = fin.frame.held_ttl;
      sum_in.held_checksum   = fin.frame.held_checksum;
      sum_in.total           = fin.running_sum + {24'b0, UDP_PROTOCOL} + {16'b0, seg}
                               + {16'b0, hdr_src} + {16'b0, hdr_dst} + {16'b0, hdr_len};
      sum_in.length_error    = (seg < UDP_HEADER_BYTES) ||
                               (fin.frame.bytes_left != 16'h0000) ||
                               (fin.frame.word_position < need);
      sum_valid_in = take || (sum_valid_ff && !sum_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sum       = sum_ff;

endmodule

`default_nettype wire

// File: rtl/ucv_fold.sv
// ucv_fold: folds the 32-bit sum, inverts it and holds the result beat.
// Depends on ucv_pkg (sum_type).
`default_nettype none

module ucv_fold import ucv_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          sum_valid,
   output logic               sum_ready,
   input  wire sum_type       sum,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [103:0]       rsp_tdata,
   output logic [1:0]         rsp_tuser
);

   logic         res_valid_ff, res_valid_in;
   logic [103:0] res_data_ff, res_data_in;
   logic [1:0]   res_user_ff, res_user_in;
   logic [16:0]  fold1;
   logic [15:0]  fold2;
   logic [15:0]  computed;
   logic         take;

   assign sum_ready = !res_valid_ff || rsp_tready;
   assign take      = sum_valid && sum_ready;

   always_comb begin
      fold1    = {1'b0, sum.total[15:0]} + {1'b0, sum.total[31:16]};
      fold2    = fold1[15:0] + {15'b0, fold1[16]};
      computed = (fold2 == WORD_POS_MAX) ? WORD_POS_MAX : ~fold2;
      res_data_in = {computed, sum.held_checksum, sum.held_ttl,
                     sum.held_ports[15:0], sum.held_ports[31:16], sum.sequence_number};
      res_user_in = {sum.length_error, sum.held_checksum == computed};
      res_valid_in = take || (res_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         res_data_ff <= res_data_in;
         res_user_ff <= res_user_in;
      end
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = res_data_ff;
   assign rsp_tuser  = res_user_ff;

endmodule

`default_nettype wire

// File: rtl/udp_checksum_verifier_top.sv
// udp_checksum_verifier_top: UDP checksum check over Ethernet frames, 16-bit words in,
// one report beat out per UDP frame. Depends on ucv_pkg, ucv_parser, ucv_sum, ucv_fold.
//
//   channel | prefix | tdata                         | tuser                  | tlast
//   --------+--------+-------------------------------+------------------------+---------------
//   frame   | req_   | data_word[15:0]               | single_byte            | last
//   report  | rsp_   | seq, ports, ttl, rx/calc sums | intact, length_error   | -
//
// One frame word is taken every cycle unless the input stalls as described below; each
// beat's two bytes are summed and added to the 32-bit running sum in the parser. After
// the last word is accepted, a report passes the input register, frame snapshot, sum and fold registers.
// Reset clears the frame state and the UDP frame counter; nothing needs a clearing pass.
// A stalled report holds in its output register while the next frame keeps streaming in;
// input stalls only when a last word finds the snapshot, sum and report registers all
// full with the report beat held back.
`default_nettype none

module udp_checksum_verifier_top import ucv_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   // frame words
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,  // [15:0] data_word
   input  wire logic         req_tuser,  // [0] single_byte
   input  wire logic         req_tlast,  // last word of the frame
   // report beats
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,  // [31:0] sequence_number, [47:32] source_port,
                                         // [63:48] dest_port, [71:64] hop_limit,
                                         // [87:72] received_sum, [103:88] computed_sum
   output logic [1:0]        rsp_tuser   // [0] intact, [1] length_error
);

   finish_type fin;
   logic       fin_valid;
   logic       fin_ready;
   sum_type    sum;
   logic       sum_valid;
   logic       sum_ready;

   // Parse the frame and snapshot its state on the last word of a UDP frame.
   ucv_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .fin_ready  (fin_ready),
      .fin_valid  (fin_valid),
      .fin        (fin)
   );

   // Add the pseudo-header and UDP header terms, check the length.
   ucv_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin       (fin),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .sum       (sum)
   );

   // Fold, invert and hold the report beat.
   ucv_fold u_fold (
      .clock      (clock),
      .reset      (reset),
      .sum_valid  (sum_valid),
      .sum_ready  (sum_ready),
      .sum        (sum),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A recomputed checksum of zero is always sent as all ones.
   a_no_zero_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[103:88] != 16'h0000)
      else $error("computed checksum reported as zero");

   // The match flag agrees with the two checksum fields it compares.
   a_intact_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata[87:72] == rsp_tdata[103:88])))
      else $error("intact flag disagrees with checksum fields");

   // No report can be pending right after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("report valid right after reset");

   // Snapshot and sum stages that are both free always let the next frame word in.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!fin_valid && !sum_valid) |-> req_tready)
      else $error("input stalled with empty downstream stages");

endmodule

`default_nettype wire

// File: tb/ucv_tb_pkg.sv
// ucv_tb_pkg: report layout and frame scoreboard for the UDP checksum verifier testbench.
// Depends on ucv_pkg for the link header length and the UDP protocol number.

package ucv_tb_pkg;
   import ucv_pkg::LINK_HEADER_BYTES;
   import ucv_pkg::UDP_PROTOCOL;

   // {rsp_tuser, rsp_tdata}, most significant field first
   typedef struct packed {
      logic        length_error;
      logic        intact;
      logic [15:0] computed_sum;
      logic [15:0] received_sum;
      logic [7:0]  hop_limit;
      logic [15:0] dest_port;
      logic [15:0] source_port;
      logic [31:0] sequence_number;
   } report_type;

   class checksum_scoreboard;
      // per-frame parse state
      int unsigned frame_pos;
      int unsigned ihl_words;
      bit          is_udp;
      bit [31:0]   pseudo_acc;
      bit [15:0]   udp_len;
      bit [15:0]   seg_remaining;
      bit [15:0]   carried_sum;
      bit [31:0]   port_pair;
      bit [7:0]    ttl_byte;
      // survives frame ends
      bit [31:0]   udp_frames;
      report_type  awaited_reports[$];
      int          mismatches;
      int          reports_checked;

      function void clear_frame();
         frame_pos     = 0;
         ihl_words     = 0;
         is_udp        = 1'b0;
         pseudo_acc    = '0;
         udp_len       = '0;
         seg_remaining = '0;
         carried_sum   = '0;
         port_pair     = '0;
         ttl_byte      = '0;
      endfunction

      // even offsets land in the upper byte of a 16-bit word
      function bit [31:0] lane(int unsigned offset, bit [7:0] b);
         return offset[0] ? {24'h0, b} : {16'h0, b, 8'h00};
      endfunction

      function void absorb_byte(bit [7:0] b);
         int unsigned p;
         int unsigned ip;
         int unsigned base;
         int unsigned u;
         if (frame_pos >= 32'hFFFF) return;
         p = frame_pos;
         frame_pos = p + 1;
         if (p < LINK_HEADER_BYTES) return;
         ip = p - LINK_HEADER_BYTES;
         if (ip == 0) ihl_words = (b[3:0] < 5) ? 5 : b[3:0];
         if (ip == 8) ttl_byte = b;
         if (ip == 9) is_udp = (b == UDP_PROTOCOL);
         if (ip >= 12 && ip <= 19) pseudo_acc += lane(ip, b);
         if (ihl_words == 0) return;
         base = ihl_words * 4;
         if (ip < base) return;
         u = ip - base;
         if (u < 4) begin
            port_pair = {port_pair[23:0], b};
         end else if (u == 4) begin
            udp_len[15:8] = b;
         end else if (u == 5) begin
            udp_len[7:0] = b;
            seg_remaining = (udp_len > 6) ? udp_len - 16'd6 : 16'd0;
         end else if (u < 8) begin
            carried_sum = {carried_sum[7:0], b};
            if (seg_remaining != 0) seg_remaining--;
         end else if (seg_remaining != 0) begin
            seg_remaining--;
            pseudo_acc += lane(u, b);
         end
      endfunction

      // note one accepted frame beat; a UDP frame end queues its report
      function void take_beat(logic [15:0] word, logic single, logic last);
         bit [31:0]  total;
         bit [47:0]  udp_head;
         bit [15:0]  calc;
         bit         bad_len;
         report_type rep;
         absorb_byte(word[15:8]);
         if (!single) absorb_byte(word[7:0]);
         if (!last) return;
         if (!is_udp) begin
            clear_frame();
            return;
         end
         total = pseudo_acc + UDP_PROTOCOL + udp_len;
         udp_head = {port_pair, udp_len};
         for (int k = 0; k < 6; k++)
            if (k < udp_len) total += lane(k, udp_head[47 - 8 * k -: 8]);
         total = {16'h0, total[15:0]} + {16'h0, total[31:16]};
         total = {16'h0, total[15:0]} + {16'h0, total[31:16]};
         calc = ~total[15:0];
         if (calc == 16'h0000) calc = 16'hFFFF;
         bad_len = udp_len < 8 || seg_remaining != 0 ||
                   frame_pos < LINK_HEADER_BYTES + ihl_words * 4 + 6;
         udp_frames++;
         rep.sequence_number = udp_frames;
         rep.source_port     = port_pair[31:16];
         rep.dest_port       = port_pair[15:0];
         rep.hop_limit       = ttl_byte;
         rep.received_sum    = carried_sum;
         rep.computed_sum    = calc;
         rep.intact          = (carried_sum == calc);
         rep.length_error    = bad_len;
         awaited_reports.push_back(rep);
         clear_frame();
      endfunction

      task log_mismatch(string msg);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want, int seq);
         if (got !== want)
            log_mismatch($sformatf("report %0d %s: got %0h, expected %0h", seq, name, got, want));
      endtask

      task check_report(logic [103:0] data, logic [1:0] flags);
         report_type got;
         report_type want;
         got = {flags, data};
         if (awaited_reports.size() == 0) begin
            log_mismatch($sformatf("report %0h arrived with none outstanding", got));
            return;
         end
         want = awaited_reports.pop_front();
         reports_checked++;
         compare_field("sequence_number", got.sequence_number, want.sequence_number,
                       reports_checked);
         compare_field("source_port", got.source_port, want.source_port, reports_checked);
         compare_field("dest_port", got.dest_port, want.dest_port, reports_checked);
         compare_field("hop_limit", got.hop_limit, want.hop_limit, reports_checked);
         compare_field("received_sum", got.received_sum, want.received_sum, reports_checked);
         compare_field("computed_sum", got.computed_sum, want.computed_sum, reports_checked);
         compare_field("intact", got.intact, want.intact, reports_checked);
         compare_field("length_error", got.length_error, want.length_error, reports_checked);
      endtask

      function int pending();
         return awaited_reports.size();
      endfunction
   endclass

endpackage

// File: tb/testbench.sv
// testbench: drives Ethernet frames into udp_checksum_verifier_top and checks every report beat.
// Depends on ucv_pkg (RTL package) and ucv_tb_pkg (report layout and scoreboard).

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ucv_pkg::LINK_HEADER_BYTES;
   import ucv_pkg::UDP_PROTOCOL;
   import ucv_tb_pkg::*;

   // how the carried UDP checksum field is filled in
   typedef enum int {CK_RANDOM, CK_ZERO, CK_MATCH, CK_FOLD} cksum_mode_type;

   localparam int EXACT_LEN   = -1;   // UDP length field = 8 + payload
   localparam int ALL_BYTES   = -1;   // send the frame untruncated
   localparam int IDLE_PCT    = 9;
   localparam int STALL_LIMIT = 2000;
   localparam int MIN_BEATS   = 900;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata  = 16'h0000;  // [15:0] data_word
   logic         req_tuser  = 1'b0;      // [0] single_byte
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;              // [31:0] seq, [47:32] sport, [63:48] dport,
                                         // [71:64] ttl, [87:72] rx sum, [103:88] calc sum
   logic [1:0]   rsp_tuser;              // [0] intact, [1] length_error

   checksum_scoreboard board = new();
   logic [7:0] frame_bytes[$];   // frame under construction
   bit         quiet = 1'b0;     // suppress idling on both sides
   int         idle_cycles = 0;
   int         words_sent = 0;
   int         frames_sent = 0;

   udp_checksum_verifier_top DUT (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   always #6 clock = ~clock;

   // Receiver side: stall at random, check each accepted report beat, and
   // track how long nothing has moved on either channel.
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!reset && rsp_tvalid && rsp_tready) board.check_report(rsp_tdata, rsp_tuser);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: end the run once no beat has moved for too long.
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // Present one beat, idling first at random; hold it until accepted.
   // tvalid stays high on return so back-to-back beats need no extra step.
   task automatic send_word(input logic [15:0] word, input logic single, input logic last);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= single;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_beat(word, single, last);
      words_sent++;
   endtask

   // Write a byte only where the (possibly truncated) frame still has one.
   function automatic void put_byte(int unsigned idx, logic [7:0] b);
      if (idx < frame_bytes.size()) frame_bytes[idx] = b;
   endfunction

   // Computed checksum of frame_bytes as the block would report it; a private
   // scoreboard instance parses the bytes, so no second copy of the math exists.
   function automatic logic [15:0] frame_sum();
      checksum_scoreboard probe = new();
      report_type         rep;
      int                 n = frame_bytes.size();
      for (int i = 0; i < n; i += 2)
         probe.take_beat({frame_bytes[i], (i + 1 < n) ? frame_bytes[i + 1] : 8'h00},
                         i + 1 >= n, i + 2 >= n);
      if (probe.pending() == 0) return 16'h0000;
      rep = probe.awaited_reports.pop_front();
      return rep.computed_sum;
   endfunction

   // Build one frame (link header, IPv4 header with options, UDP header and
   // payload), shape it as asked, and stream it out as beats.
   task automatic send_frame(input logic [3:0] ihl_nib, input logic [7:0] proto,
                             input int payload_len, input int len_field, input int keep,
                             input cksum_mode_type ck, input bit splits);
      int unsigned ihl_eff;
      int unsigned udp_at;
      int unsigned idx;
      logic [15:0] len_val;
      logic [15:0] ck_val;
      logic [7:0]  hi_b;
      logic [7:0]  lo_b;
      logic        single;
      frame_bytes.delete();
      ihl_eff = (ihl_nib < 5) ? 5 : ihl_nib;
      repeat (LINK_HEADER_BYTES) frame_bytes.push_back(8'($urandom));
      repeat (ihl_eff * 4) frame_bytes.push_back(8'($urandom));
      frame_bytes[LINK_HEADER_BYTES]     = {4'($urandom), ihl_nib};
      frame_bytes[LINK_HEADER_BYTES + 9] = proto;
      udp_at  = frame_bytes.size();
      len_val = (len_field == EXACT_LEN) ? 16'(payload_len + 8) : 16'(len_field);
      repeat (4) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(len_val[15:8]);
      frame_bytes.push_back(len_val[7:0]);
      repeat (2 + payload_len) frame_bytes.push_back(8'($urandom));
      // truncate first, so the checksum reflects the bytes actually sent
      if (keep != ALL_BYTES)
         while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());

      if (ck == CK_ZERO) begin
         put_byte(udp_at + 6, 8'h00);
         put_byte(udp_at + 7, 8'h00);
      end
      // make the ones' complement sum come out all ones, so the inverted
      // result is zero and must be reported as FFFF
      if (ck == CK_FOLD) begin
         put_byte(udp_at + 8, 8'h00);
         put_byte(udp_at + 9, 8'h00);
         ck_val = frame_sum();
         put_byte(udp_at + 8, ck_val[15:8]);
         put_byte(udp_at + 9, ck_val[7:0]);
      end
      if (ck == CK_MATCH || ck == CK_FOLD) begin
         ck_val = frame_sum();
         put_byte(udp_at + 6, ck_val[15:8]);
         put_byte(udp_at + 7, ck_val[7:0]);
      end

      // stream: an odd tail goes out as a single-byte beat; with splits on,
      // single-byte beats also show up mid-frame; the unused low byte is junk
      idx = 0;
      while (idx < frame_bytes.size()) begin
         hi_b   = frame_bytes[idx];
         single = (idx + 1 == frame_bytes.size()) || (splits && $urandom_range(0, 99) < 15);
         lo_b   = single ? 8'($urandom) : frame_bytes[idx + 1];
         idx    += single ? 1 : 2;
         send_word({hi_b, lo_b}, single, idx >= frame_bytes.size());
      end
      frames_sent++;
   endtask

   initial begin
      int             rnd_frames;
      int             pick;
      int             plen;
      logic [3:0]     ihl;
      logic [7:0]     proto;
      int             lenf;
      int             keep;
      cksum_mode_type ck;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed frames ----
      send_frame(4'd5, UDP_PROTOCOL, 12, EXACT_LEN, ALL_BYTES, CK_MATCH, 1'b0);
      send_frame(4'd5, UDP_PROTOCOL, 13, EXACT_LEN, ALL_BYTES, CK_RANDOM, 1'b0); // odd tail
      send_frame(4'd5, UDP_PROTOCOL, 10, EXACT_LEN, ALL_BYTES, CK_ZERO, 1'b0);   // zero carried
      send_frame(4'd5, UDP_PROTOCOL, 6, EXACT_LEN, ALL_BYTES, CK_FOLD, 1'b0);    // zero -> FFFF
      send_frame(4'd0, UDP_PROTOCOL, 4, EXACT_LEN, ALL_BYTES, CK_MATCH, 1'b0);   // IHL below 5
      send_frame(4'd15, UDP_PROTOCOL, 9, EXACT_LEN, ALL_BYTES, CK_MATCH, 1'b0);  // max options
      send_frame(4'd5, 8'd6, 12, EXACT_LEN, ALL_BYTES, CK_RANDOM, 1'b0);         // not UDP
      send_frame(4'd5, UDP_PROTOCOL, 10, 0, ALL_BYTES, CK_RANDOM, 1'b0);         // length 0
      send_frame(4'd5, UDP_PROTOCOL, 10, 3, ALL_BYTES, CK_MATCH, 1'b0);          // header cut
      send_frame(4'd5, UDP_PROTOCOL, 8, 36, ALL_BYTES, CK_MATCH, 1'b0);          // overlong len
      send_frame(4'd5, UDP_PROTOCOL, 8, EXACT_LEN, 37, CK_RANDOM, 1'b0);         // no len field
      send_frame(4'd5, UDP_PROTOCOL, 8, EXACT_LEN, 20, CK_RANDOM, 1'b0);         // no protocol
      send_frame(4'd5, UDP_PROTOCOL, 20, 12, ALL_BYTES, CK_MATCH, 1'b0);         // trailing bytes
      send_frame(4'd5, UDP_PROTOCOL, 16, EXACT_LEN, ALL_BYTES, CK_MATCH, 1'b1);  // split beats
      send_frame(4'd5, UDP_PROTOCOL, 0, EXACT_LEN, ALL_BYTES, CK_MATCH, 1'b0);   // header only

      // ---- random frames: mostly well formed, the rest malformed ----
      rnd_frames = 0;
      while (words_sent < MIN_BEATS) begin
         quiet = (rnd_frames >= 2 && rnd_frames < 8);   // burst with no idling
         pick  = $urandom_range(0, 99);
         if (pick < 70) begin
            ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
            plen = $urandom_range(0, 40);
            pick = $urandom_range(0, 9);
            ck   = (pick < 5) ? CK_MATCH : (pick < 8) ? CK_RANDOM :
                   (pick < 9) ? CK_ZERO : CK_FOLD;
            send_frame(ihl, UDP_PROTOCOL, plen, EXACT_LEN, ALL_BYTES, ck,
                       $urandom_range(0, 4) == 0);
         end else begin
            ihl   = 4'($urandom);
            proto = $urandom_range(0, 1) ? UDP_PROTOCOL : 8'($urandom);
            plen  = $urandom_range(0, 40);
            lenf  = $urandom_range(0, 2) ? int'($urandom_range(0, 60)) : EXACT_LEN;
            keep  = $urandom_range(0, 1) ? int'($urandom_range(1, 110)) : ALL_BYTES;
            ck    = $urandom_range(0, 1) ? CK_MATCH : CK_RANDOM;
            send_frame(ihl, proto, plen, lenf, keep, ck, $urandom_range(0, 1));
         end
         rnd_frames++;
      end
      quiet = 1'b0;

      // drain: drop tvalid, wait for every outstanding report, then keep the
      // clock running so that anything unexpected can still surface
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Ran %0d frames (%0d beats); %0d UDP reports checked, %0d mismatches.",
               frames_sent, words_sent, board.reports_checked, board.mismatches);
      $display("Mix: short/long IP headers, odd and overlong UDP lengths, truncation, %s",
               "split beats and non-UDP frames.");
      if (board.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
